// File: rtl/page_framebuffer_sprite_overlay_core_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the page frame buffer sprite overlay core
// Clocked on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef PAGE_FRAMEBUFFER_SPRITE_OVERLAY_CORE_DEFINES_SVH
`define PAGE_FRAMEBUFFER_SPRITE_OVERLAY_CORE_DEFINES_SVH

// same-cycle implication
`define PFSO_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PFSO_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/pfso_pkg.sv
// ----------------------------------------------------------------------------
// pfso_pkg
// Types, constants and tile helpers for the sprite overlay core.
// ----------------------------------------------------------------------------
package pfso_pkg;

  localparam int WIDTH_PIXELS  = 128;
  localparam int HEIGHT_PIXELS = 64;
  localparam int TILE_COLS     = WIDTH_PIXELS / 8;
  localparam int TILE_PAGES    = HEIGHT_PIXELS / 8;
  localparam int TILE_COUNT    = TILE_COLS * TILE_PAGES;
  localparam int ADDR_W        = $clog2(TILE_COUNT);

  localparam logic [1:0] MODE_FILL   = 2'd0;
  localparam logic [1:0] MODE_TILE   = 2'd1;
  localparam logic [1:0] MODE_SPRITE = 2'd2;

  localparam logic [1:0] LAST_QUAD   = 2'd3;

  typedef enum logic {
    ST_IDLE,
    ST_SPRITE
  } state_t;

  typedef struct packed {
    logic              rd_en;
    logic              wr_en;
    logic              fill_en;
    logic              fill_ones;
    logic [ADDR_W-1:0] addr;
    logic [63:0]       wdata;
  } store_req_t;

  typedef struct packed {
    logic [2:0] xoff;
    logic [2:0] yoff;
    logic       right;
    logic       bottom;
  } quad_ctrl_t;

  typedef struct packed {
    logic [4:0] col;
    logic [3:0] page;
    logic       on_screen;
    logic       last;
  } quad_info_t;

  typedef struct packed {
    logic [3:0]  page;
    logic [7:0]  start_column;
    logic [63:0] tile_data;
    logic        off_screen;
    logic        last;
  } out_item_t;

  function automatic logic tile_on_screen(logic [4:0] col, logic [3:0] page);
    return (int'(col) < TILE_COLS) && (int'(page) < TILE_PAGES);
  endfunction

  function automatic logic [ADDR_W-1:0] tile_addr(logic [4:0] col, logic [3:0] page);
    return ADDR_W'(int'(page) * TILE_COLS + int'(col));
  endfunction

  // tile touched by quadrant q of a sprite at tile c,p (bit0 right, bit1 bottom)
  function automatic quad_info_t quad_info(logic [3:0] c, logic [2:0] p, logic [1:0] q);
    quad_info_t qi;
    qi.col       = {1'b0, c} + 5'(q[0]);
    qi.page      = {1'b0, p} + 4'(q[1]);
    qi.on_screen = tile_on_screen(qi.col, qi.page);
    qi.last      = (q == LAST_QUAD);
    return qi;
  endfunction

endpackage

// File: rtl/pfso_channels.sv
// ----------------------------------------------------------------------------
// pfso channels
// Valid/ready channels for command words in and composed tile words out.
// ----------------------------------------------------------------------------
interface pfso_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic        fill_ones;
  logic [3:0]  tile_column;
  logic [2:0]  tile_page;
  logic [6:0]  sprite_x;
  logic [5:0]  sprite_y;
  logic [63:0] pattern;

  modport source (output valid, mode, fill_ones, tile_column, tile_page,
                  sprite_x, sprite_y, pattern, input ready);
  modport sink   (input valid, mode, fill_ones, tile_column, tile_page,
                  sprite_x, sprite_y, pattern, output ready);
endinterface

interface pfso_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  page;
  logic [7:0]  start_column;
  logic [63:0] tile_data;
  logic        off_screen;
  logic        last;

  modport source (output valid, page, start_column, tile_data, off_screen, last,
                  input ready);
  modport sink   (input valid, page, start_column, tile_data, off_screen, last,
                  output ready);
endinterface

// File: rtl/pfso_tile_store.sv
// ----------------------------------------------------------------------------
// pfso_tile_store
// Tile memory, one port, registered read. Per-tile valid bits plus a fill
// value let a fill or reset clear every tile without a write; invalid tiles read as the fill.
// ----------------------------------------------------------------------------
module pfso_tile_store (
  input  logic                 clk,
  input  logic                 rst_n,
  input  pfso_pkg::store_req_t req,
  output logic [63:0]          rd_data
);

  logic [63:0] mem [pfso_pkg::TILE_COUNT];
  logic [pfso_pkg::TILE_COUNT-1:0] valid_r;
  logic        fill_r;
  logic [63:0] rd_data_r;
  logic        rd_valid_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.addr] <= req.wdata;
    end
    if (req.rd_en) begin
      rd_data_r <= mem[req.addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= '0;
      fill_r     <= 1'b0;
      rd_valid_r <= 1'b0;
    end else begin
      if (req.fill_en) begin
        valid_r <= '0;
        fill_r  <= req.fill_ones;
      end else if (req.wr_en) begin
        valid_r[req.addr] <= 1'b1;
      end
      if (req.rd_en) begin
        rd_valid_r <= valid_r[req.addr];
      end
    end
  end

  assign rd_data = rd_valid_r ? rd_data_r : {64{fill_r}};

endmodule

// File: rtl/pfso_col_lane.sv
// ----------------------------------------------------------------------------
// pfso_col_lane
// One column byte of a composed tile: picks the sprite byte for this column,
// shifts it by the row offset and ORs it over the background byte.
// ----------------------------------------------------------------------------
module pfso_col_lane (
  input  logic [2:0]           lane_idx,
  input  pfso_pkg::quad_ctrl_t ctrl,
  input  logic [63:0]          sprite,
  input  logic [7:0]           bg_byte,
  output logic [7:0]           out_byte
);

  logic       covered;
  logic [2:0] src_idx;
  logic [7:0] src;
  logic [7:0] shifted;

  always_comb begin
    covered = ctrl.right ? (lane_idx < ctrl.xoff) : (lane_idx >= ctrl.xoff);
    // left and right halves index the sprite the same way modulo 8
    src_idx = lane_idx - ctrl.xoff;
    src     = sprite[{src_idx, 3'b000} +: 8];
    if (ctrl.bottom) begin
      shifted = (ctrl.yoff == 3'd0) ? 8'h00 : (src >> (4'd8 - {1'b0, ctrl.yoff}));
    end else begin
      shifted = src << ctrl.yoff;
    end
    out_byte = bg_byte | (covered ? shifted : 8'h00);
  end

endmodule

// File: rtl/pfso_compose.sv
// ----------------------------------------------------------------------------
// pfso_compose
// Eight column lanes in parallel and the merge of their bytes into one
// result word with page, start column and edge flags.
// ----------------------------------------------------------------------------
module pfso_compose (
  input  pfso_pkg::quad_ctrl_t ctrl,
  input  pfso_pkg::quad_info_t info,
  input  logic [63:0]          sprite,
  input  logic [63:0]          stored,
  output pfso_pkg::out_item_t  item
);

  logic [63:0] bg;
  logic [63:0] merged;

  // beyond the edge the background is blank
  assign bg = info.on_screen ? stored : 64'h0;

  for (genvar i = 0; i < 8; i++) begin : g_lane
    pfso_col_lane u_lane (
      .lane_idx (3'(i)),
      .ctrl     (ctrl),
      .sprite   (sprite),
      .bg_byte  (bg[8*i +: 8]),
      .out_byte (merged[8*i +: 8])
    );
  end

  always_comb begin
    item.page         = info.page;
    item.start_column = {info.col, 3'b000};
    item.tile_data    = merged;
    item.off_screen   = !info.on_screen;
    item.last         = info.last;
  end

endmodule

// File: rtl/page_framebuffer_sprite_overlay_core.sv
// ----------------------------------------------------------------------------
// page_framebuffer_sprite_overlay_core
// Fill and tile-write words are done on acceptance; a fill clears the valid bits.
// A sprite word reads its four tiles one a cycle, while the output is free,
// from the single store port; each read is registered in the store, then its
// result in the output register; the next word is taken once the fourth loads.
// Synchronous active-low reset; the store reads all zeros afterwards.
// ----------------------------------------------------------------------------
`include "page_framebuffer_sprite_overlay_core_defines.svh"

module page_framebuffer_sprite_overlay_core (
  input  logic        clk,
  input  logic        rst_n,
  pfso_in_if.sink     in_ch,
  pfso_out_if.source  out_ch
);

  pfso_pkg::state_t     state_r, state_nxt;
  logic [1:0]           q_r, q_nxt;
  logic [3:0]           c_r;
  logic [2:0]           p_r;
  logic [2:0]           xo_r;
  logic [2:0]           yo_r;
  logic [63:0]          spr_r;

  pfso_pkg::out_item_t  out_item_r;
  logic                 out_valid_r;

  pfso_pkg::store_req_t req;
  pfso_pkg::quad_info_t cur_info;
  pfso_pkg::quad_info_t rd_info;
  pfso_pkg::quad_ctrl_t ctrl;
  pfso_pkg::out_item_t  item;
  logic [63:0]          rd_data;
  logic                 in_accept;
  logic                 out_free;
  logic                 load;

  assign in_ch.ready = (state_r == pfso_pkg::ST_IDLE);
  assign in_accept   = in_ch.valid && in_ch.ready;
  assign out_free    = !out_valid_r || out_ch.ready;
  assign load        = (state_r == pfso_pkg::ST_SPRITE) && out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pfso_pkg::ST_IDLE;
      q_r     <= 2'd0;
    end else begin
      state_r <= state_nxt;
      q_r     <= q_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    q_nxt     = q_r;
    case (state_r)
      pfso_pkg::ST_IDLE: begin
        if (in_accept && in_ch.mode == pfso_pkg::MODE_SPRITE) begin
          state_nxt = pfso_pkg::ST_SPRITE;
          q_nxt     = 2'd0;
        end
      end
      pfso_pkg::ST_SPRITE: begin
        if (load) begin
          if (q_r == pfso_pkg::LAST_QUAD) begin
            state_nxt = pfso_pkg::ST_IDLE;
            q_nxt     = 2'd0;
          end else begin
            q_nxt = q_r + 2'd1;
          end
        end
      end
      default: begin
        state_nxt = pfso_pkg::ST_IDLE;
        q_nxt     = 2'd0;
      end
    endcase
  end

  // sprite geometry held for the four tiles
  always_ff @(posedge clk) begin
    if (in_accept && in_ch.mode == pfso_pkg::MODE_SPRITE) begin
      c_r   <= in_ch.sprite_x[6:3];
      p_r   <= in_ch.sprite_y[5:3];
      xo_r  <= in_ch.sprite_x[2:0];
      yo_r  <= in_ch.sprite_y[2:0];
      spr_r <= in_ch.pattern;
    end
  end

  always_comb begin
    cur_info = pfso_pkg::quad_info(c_r, p_r, q_r);
    if (state_r == pfso_pkg::ST_IDLE) begin
      rd_info = pfso_pkg::quad_info(in_ch.sprite_x[6:3], in_ch.sprite_y[5:3], 2'd0);
    end else begin
      rd_info = pfso_pkg::quad_info(c_r, p_r, q_nxt);
    end

    req.fill_en   = in_accept && (in_ch.mode == pfso_pkg::MODE_FILL);
    req.fill_ones = in_ch.fill_ones;
    req.wr_en     = in_accept && (in_ch.mode == pfso_pkg::MODE_TILE) &&
                    pfso_pkg::tile_on_screen({1'b0, in_ch.tile_column},
                                             {1'b0, in_ch.tile_page});
    req.wdata     = in_ch.pattern;
    // read for tile 0 on acceptance, then the following tile as each result loads
    req.rd_en     = (in_accept && (in_ch.mode == pfso_pkg::MODE_SPRITE)) ||
                    (load && (q_r != pfso_pkg::LAST_QUAD));
    if (state_r == pfso_pkg::ST_IDLE && in_ch.mode == pfso_pkg::MODE_TILE) begin
      req.addr = pfso_pkg::tile_addr({1'b0, in_ch.tile_column}, {1'b0, in_ch.tile_page});
    end else begin
      req.addr = pfso_pkg::tile_addr(rd_info.col, rd_info.page);
    end

    ctrl.xoff   = xo_r;
    ctrl.yoff   = yo_r;
    ctrl.right  = q_r[0];
    ctrl.bottom = q_r[1];
  end

  pfso_tile_store u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (req),
    .rd_data (rd_data)
  );

  pfso_compose u_compose (
    .ctrl   (ctrl),
    .info   (cur_info),
    .sprite (spr_r),
    .stored (rd_data),
    .item   (item)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_item_r <= item;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.page         = out_item_r.page;
  assign out_ch.start_column = out_item_r.start_column;
  assign out_ch.tile_data    = out_item_r.tile_data;
  assign out_ch.off_screen   = out_item_r.off_screen;
  assign out_ch.last         = out_item_r.last;

  // a word following the last tile can only open a new burst
  `PFSO_ASSERT_NEXT(a_last_ends_burst,
                    out_valid_r && out_ch.ready && out_item_r.last,
                    !out_valid_r || !out_item_r.last, "last tile repeated")
  `PFSO_ASSERT_SAME(a_on_screen_range, out_valid_r && !out_item_r.off_screen,
                    (int'(out_item_r.page) < pfso_pkg::TILE_PAGES) &&
                    (int'(out_item_r.start_column) < pfso_pkg::WIDTH_PIXELS),
                    "on-screen tile out of range")
  `PFSO_ASSERT_NEXT(a_sprite_start, in_accept && in_ch.mode == pfso_pkg::MODE_SPRITE,
                    state_r == pfso_pkg::ST_SPRITE && q_r == 2'd0,
                    "sprite burst not started")
  `PFSO_ASSERT_SAME(a_no_read_on_write, req.wr_en || req.fill_en, !req.rd_en,
                    "store read and write collide")

endmodule

// File: tb/tb_page_framebuffer_sprite_overlay_core.sv
// ----------------------------------------------------------------------------
// tb_page_framebuffer_sprite_overlay_core
// Drives fill, tile write, sprite and ignored command words through the
// valid/ready input channel and checks every composed tile word against a
// predictor that keeps its own copy of the frame store. A directed set covers
// the screen edges and offsets, then random words run under four idling
// phases on both channels.
// ----------------------------------------------------------------------------
module tb_page_framebuffer_sprite_overlay_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] MODE_NONE     = 2'd3;
  localparam int         STALL_LIMIT   = 4000;
  localparam int         SETTLE_CYCLES = 20;
  localparam int         PHASE_WORDS   = 40;

  typedef struct packed {
    logic [1:0]  mode;
    logic        fill_ones;
    logic [3:0]  tile_column;
    logic [2:0]  tile_page;
    logic [6:0]  sprite_x;
    logic [5:0]  sprite_y;
    logic [63:0] pattern;
  } cmd_word_t;

  class overlay_scoreboard;
    logic [63:0]         tiles [pfso_pkg::TILE_COUNT];
    pfso_pkg::out_item_t expected_tiles [$];
    int                  errors;

    function new();
      foreach (tiles[i]) tiles[i] = 64'h0;
      errors = 0;
    endfunction

    function int pending();
      return expected_tiles.size();
    endfunction

    // one of the four tiles a sprite touches, composed over the stored background
    function pfso_pkg::out_item_t compose_quad(logic [63:0] spr, logic [4:0] col,
                                               logic [3:0] pg, logic [2:0] xo,
                                               logic [2:0] yo, bit right,
                                               bit bottom, bit last_quad);
      pfso_pkg::out_item_t r;
      logic [63:0] bg;
      logic [7:0]  b;
      logic [7:0]  s;
      logic [15:0] shifted;
      bit          on;
      int          si;
      on = (int'(col) < pfso_pkg::TILE_COLS) && (int'(pg) < pfso_pkg::TILE_PAGES);
      bg = on ? tiles[int'(pg) * pfso_pkg::TILE_COLS + int'(col)] : 64'h0;
      r.tile_data = 64'h0;
      for (int i = 0; i < 8; i++) begin
        b = bg[8*i +: 8];
        if (right ? (i < int'(xo)) : (i >= int'(xo))) begin
          si = right ? (8 - int'(xo) + i) : (i - int'(xo));
          s = spr[8*si +: 8];
          // upper byte holds the rows spilling into the page below
          shifted = {8'h00, s} << yo;
          b = b | (bottom ? shifted[15:8] : shifted[7:0]);
        end
        r.tile_data[8*i +: 8] = b;
      end
      r.page         = pg;
      r.start_column = 8'(int'(col) * 8);
      r.off_screen   = !on;
      r.last         = last_quad;
      return r;
    endfunction

    function void note_word(cmd_word_t w);
      logic [3:0] c;
      logic [2:0] p;
      case (w.mode)
        pfso_pkg::MODE_FILL: begin
          foreach (tiles[i]) tiles[i] = w.fill_ones ? 64'hFFFF_FFFF_FFFF_FFFF : 64'h0;
        end
        pfso_pkg::MODE_TILE: begin
          tiles[int'(w.tile_page) * pfso_pkg::TILE_COLS + int'(w.tile_column)] = w.pattern;
        end
        pfso_pkg::MODE_SPRITE: begin
          c = w.sprite_x[6:3];
          p = w.sprite_y[5:3];
          for (int q = 0; q < 4; q++) begin
            expected_tiles.push_back(compose_quad(w.pattern, {1'b0, c} + 5'(q % 2),
                                                  {1'b0, p} + 4'(q / 2),
                                                  w.sprite_x[2:0], w.sprite_y[2:0],
                                                  (q % 2) == 1, q >= 2, q == 3));
          end
        end
        default: begin
        end
      endcase
    endfunction

    function bit differs(string field, logic [63:0] exp, logic [63:0] act);
      if (act !== exp) begin
        $display("%0t ns: %s expected %h actual %h", $time, field, exp, act);
        return 1'b1;
      end
      return 1'b0;
    endfunction

    function void check_tile(pfso_pkg::out_item_t got);
      pfso_pkg::out_item_t exp;
      bit                  bad;
      if (expected_tiles.size() == 0) begin
        $display("%0t ns: tile word with none expected, page %0d column %0d data %h",
                 $time, got.page, got.start_column, got.tile_data);
        errors++;
        return;
      end
      exp = expected_tiles.pop_front();
      bad = differs("page", 64'(exp.page), 64'(got.page))
          | differs("start_column", 64'(exp.start_column), 64'(got.start_column))
          | differs("tile_data", exp.tile_data, got.tile_data)
          | differs("off_screen", 64'(exp.off_screen), 64'(got.off_screen))
          | differs("last", 64'(exp.last), 64'(got.last));
      if (bad) errors++;
    endfunction
  endclass

  logic clk;
  logic rst_n;

  pfso_in_if  in_ch ();
  pfso_out_if out_ch ();

  page_framebuffer_sprite_overlay_core dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  overlay_scoreboard sb;
  int send_idle_pct;
  int recv_stall_pct;
  int quiet_cycles;

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // receiver: ready changes on the falling edge only
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ch.ready = ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // monitor: results checked before the same edge's command is noted
  always @(posedge clk) begin
    pfso_pkg::out_item_t got;
    cmd_word_t           w;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        got.page         = out_ch.page;
        got.start_column = out_ch.start_column;
        got.tile_data    = out_ch.tile_data;
        got.off_screen   = out_ch.off_screen;
        got.last         = out_ch.last;
        sb.check_tile(got);
      end
      if (in_ch.valid && in_ch.ready) begin
        w.mode        = in_ch.mode;
        w.fill_ones   = in_ch.fill_ones;
        w.tile_column = in_ch.tile_column;
        w.tile_page   = in_ch.tile_page;
        w.sprite_x    = in_ch.sprite_x;
        w.sprite_y    = in_ch.sprite_y;
        w.pattern     = in_ch.pattern;
        sb.note_word(w);
      end
      if ((out_ch.valid && out_ch.ready) || (in_ch.valid && in_ch.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
          $display("%0t ns: no word moved for %0d cycles", $time, quiet_cycles);
          $display("*** FAILED ***");
          $finish;
        end
      end
    end
  end

  // called on a falling edge; returns on the falling edge after acceptance
  task automatic drive_word(cmd_word_t w);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.mode        = w.mode;
    in_ch.fill_ones   = w.fill_ones;
    in_ch.tile_column = w.tile_column;
    in_ch.tile_page   = w.tile_page;
    in_ch.sprite_x    = w.sprite_x;
    in_ch.sprite_y    = w.sprite_y;
    in_ch.pattern     = w.pattern;
    in_ch.valid       = 1'b1;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send(logic [1:0] mode, logic fill, logic [3:0] col, logic [2:0] pg,
                      logic [6:0] x, logic [5:0] y, logic [63:0] pat);
    cmd_word_t w;
    w = '{mode, fill, col, pg, x, y, pat};
    drive_word(w);
  endtask

  task automatic wait_drained();
    in_ch.valid = 1'b0;
    while (sb.pending() != 0) @(negedge clk);
  endtask

  task automatic random_words(int count);
    cmd_word_t w;
    int        sent;
    int        r;
    sent = 0;
    while (sent < count) begin
      r = $urandom_range(99);
      w.mode = (r < 4)  ? pfso_pkg::MODE_FILL :
               (r < 38) ? pfso_pkg::MODE_TILE :
               (r < 92) ? pfso_pkg::MODE_SPRITE : MODE_NONE;
      w.fill_ones   = ($urandom_range(99) < 30);
      w.tile_column = 4'($urandom);
      w.tile_page   = 3'($urandom);
      // a fifth of the sprites sit on a tile boundary or at the far edge
      if ($urandom_range(4) == 0) begin
        w.sprite_x = {4'($urandom), ($urandom_range(1) != 0) ? 3'd7 : 3'd0};
        w.sprite_y = {3'($urandom), ($urandom_range(1) != 0) ? 3'd7 : 3'd0};
      end else begin
        w.sprite_x = 7'($urandom);
        w.sprite_y = 6'($urandom);
      end
      case ($urandom_range(7))
        0:       w.pattern = 64'h0;
        1:       w.pattern = 64'hFFFF_FFFF_FFFF_FFFF;
        2:       w.pattern = 64'h1 << $urandom_range(63);
        default: w.pattern = {$urandom, $urandom};
      endcase
      drive_word(w);
      sent++;
    end
  endtask

  initial begin
    sb = new();
    quiet_cycles      = 0;
    send_idle_pct     = 0;
    recv_stall_pct    = 0;
    rst_n             = 1'b0;
    in_ch.valid       = 1'b0;
    in_ch.mode        = pfso_pkg::MODE_FILL;
    in_ch.fill_ones   = 1'b0;
    in_ch.tile_column = 4'd0;
    in_ch.tile_page   = 3'd0;
    in_ch.sprite_x    = 7'd0;
    in_ch.sprite_y    = 6'd0;
    in_ch.pattern     = 64'h0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // aligned sprite on an empty store, then both far edges
    send(pfso_pkg::MODE_SPRITE, 1'b0, 4'd0, 3'd0, 7'd0, 6'd0, 64'hFFFF_FFFF_FFFF_FFFF);
    send(pfso_pkg::MODE_SPRITE, 1'b1, 4'd15, 3'd7, 7'd127, 6'd63, 64'h0123_4567_89AB_CDEF);
    send(pfso_pkg::MODE_SPRITE, 1'b0, 4'd0, 3'd0, 7'd120, 6'd0, 64'hFFFF_FFFF_FFFF_FFFF);
    send(pfso_pkg::MODE_TILE, 1'b0, 4'd0, 3'd0, 7'd0, 6'd0, 64'hA5A5_A5A5_A5A5_A5A5);
    send(pfso_pkg::MODE_TILE, 1'b1, 4'd15, 3'd7, 7'd127, 6'd63, 64'h5A5A_5A5A_5A5A_5A5A);
    send(pfso_pkg::MODE_TILE, 1'b0, 4'd1, 3'd0, 7'd0, 6'd0, 64'h0F0F_0F0F_F0F0_F0F0);
    send(pfso_pkg::MODE_TILE, 1'b0, 4'd0, 3'd1, 7'd0, 6'd0, 64'h8040_2010_0804_0201);
    send(pfso_pkg::MODE_SPRITE, 1'b0, 4'd0, 3'd0, 7'd3, 6'd5, 64'h8100_00FF_1824_4281);
    send(pfso_pkg::MODE_SPRITE, 1'b0, 4'd0, 3'd0, 7'd125, 6'd61, 64'hFFFF_FFFF_FFFF_FFFF);
    // ignored mode must leave tile 0,0 untouched
    send(MODE_NONE, 1'b1, 4'd0, 3'd0, 7'd0, 6'd0, 64'h0);
    send(pfso_pkg::MODE_SPRITE, 1'b0, 4'd0, 3'd0, 7'd0, 6'd0, 64'h0);
    send(pfso_pkg::MODE_FILL, 1'b1, 4'd3, 3'd2, 7'd1, 6'd1, 64'hDEAD_BEEF_0000_0001);
    send(pfso_pkg::MODE_SPRITE, 1'b0, 4'd0, 3'd0, 7'd64, 6'd32, 64'h0);
    send(pfso_pkg::MODE_SPRITE, 1'b0, 4'd0, 3'd0, 7'd127, 6'd63, 64'h0);
    send(pfso_pkg::MODE_SPRITE, 1'b0, 4'd0, 3'd0, 7'd7, 6'd7, 64'hFFFF_FFFF_FFFF_FFFF);
    send(pfso_pkg::MODE_FILL, 1'b0, 4'd15, 3'd7, 7'd127, 6'd63, 64'hFFFF_FFFF_FFFF_FFFF);
    send(pfso_pkg::MODE_SPRITE, 1'b1, 4'd0, 3'd0, 7'd63, 6'd39, 64'hC3A5_9966_1E78_F00F);
    send(pfso_pkg::MODE_TILE, 1'b0, 4'd15, 3'd0, 7'd0, 6'd0, 64'hFFFF_FFFF_FFFF_FFFF);
    send(pfso_pkg::MODE_SPRITE, 1'b0, 4'd0, 3'd0, 7'd127, 6'd0, 64'h0);
    send(pfso_pkg::MODE_SPRITE, 1'b0, 4'd0, 3'd0, 7'd121, 6'd6, 64'h7E81_A5C3_3CFF_0018);

    random_words(PHASE_WORDS);

    send_idle_pct = 81;
    random_words(PHASE_WORDS);
    wait_drained();

    send_idle_pct  = 0;
    recv_stall_pct = 81;
    random_words(PHASE_WORDS);

    send_idle_pct  = 35;
    recv_stall_pct = 35;
    random_words(PHASE_WORDS);

    in_ch.valid = 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.pending() != 0) begin
      $display("%0t ns: %0d tile words never arrived", $time, sb.pending());
      sb.errors++;
    end
    if (sb.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
